/* sv/rvg_pkg.sv */
// Shared types and constants for the regular polygon vertex generator.
// No dependencies; imported by every module of the block.
package rvg_pkg;

   localparam int IDX_W         = 6;
   localparam int SIDES_W       = 7;
   localparam int COORD_W       = 32;
   localparam int RAD_W         = 31;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 32;
   localparam int CORDIC_STAGES = 28;
   localparam int CW            = 34;
   localparam int Q_DEPTH       = 4;
   localparam int Q_PTR_W       = $clog2(Q_DEPTH);

   localparam logic [31:0] CORDIC_GAIN = 32'd652032874;

   localparam logic [31:0] ATAN_TABLE [CORDIC_STAGES] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
      32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41721,
      32'd20860,     32'd10430,     32'd5215,      32'd2607,     32'd1303,
      32'd651,       32'd325,       32'd162,       32'd81,       32'd40,
      32'd20,        32'd10,        32'd5
   };

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CENTER_X = 2'd0,
      CSR_CENTER_Y = 2'd1,
      CSR_RADIUS   = 2'd2,
      CSR_SIDES    = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic [SIDES_W:0] num;
      logic [SIDES_W:0] den;
      logic             in_range;
      logic             last;
   } item_type;

endpackage

/* sv/rvg_req_if.sv */
// Request channel: valid/ready handshake carrying one vertex index.
// Depends on rvg_pkg for the field width.
interface rvg_req_if import rvg_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] vertex_index;

   modport source  (output valid, output vertex_index, input ready);
   modport sink    (input valid, input vertex_index, output ready);
   modport monitor (input valid, input vertex_index, input ready);
endinterface

/* sv/rvg_rsp_if.sv */
// Response channel: valid/ready handshake carrying one computed vertex.
// Depends on rvg_pkg for the field widths.
interface rvg_rsp_if import rvg_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] x;
   logic signed [COORD_W-1:0] y;
   logic                      in_range;
   logic                      last;

   modport source  (output valid, output x, output y, output in_range, output last,
                    input ready);
   modport sink    (input valid, input x, input y, input in_range, input last,
                    output ready);
   modport monitor (input valid, input x, input y, input in_range, input last,
                    input ready);
endinterface

/* sv/rvg_front.sv */
// Front end: takes request transfers, classifies the index against sides
// and forms the divider operands. Depends on rvg_pkg and rvg_req_if.
module rvg_front import rvg_pkg::*; #(
   parameter int MAX_SIDES = 64
) (
   input  logic               clock,
   input  logic               reset,
   rvg_req_if.sink            req,
   input  logic [SIDES_W-1:0] sides,
   output item_type           item,
   output logic               item_valid,
   input  logic               item_ready
);

   logic               fe_vld_ff, fe_vld_in;
   item_type           fe_item_ff, fe_item_in;
   logic [SIDES_W-1:0] s_eff;
   logic [SIDES_W-1:0] idx_w;
   logic               xfer;

   assign req.ready = !fe_vld_ff || item_ready;
   assign xfer      = req.valid && req.ready;

   always_comb begin
      if ({{(32-SIDES_W){1'b0}}, sides} > 32'(MAX_SIDES)) begin
         s_eff = SIDES_W'(MAX_SIDES);
      end else begin
         s_eff = sides;
      end
      idx_w               = {1'b0, req.vertex_index};
      fe_item_in.in_range = (s_eff != '0) && (idx_w < s_eff);
      fe_item_in.last     = fe_item_in.in_range && (idx_w == s_eff - SIDES_W'(1));
      fe_item_in.num      = {1'b0, req.vertex_index, ~s_eff[0]};
      fe_item_in.den      = {s_eff, 1'b0};
      fe_vld_in           = (fe_vld_ff && !item_ready) || xfer;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fe_vld_ff <= 1'b0;
      end else begin
         fe_vld_ff <= fe_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (xfer) begin
         fe_item_ff <= fe_item_in;
      end
   end

   assign item       = fe_item_ff;
   assign item_valid = fe_vld_ff;

endmodule

/* sv/rvg_fifo.sv */
// Short queue between front end and back end.
// Depends on rvg_pkg for the entry type and depth.
module rvg_fifo import rvg_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_en,
   input  item_type wr_data,
   output logic     full,
   input  logic     rd_en,
   output item_type rd_data,
   output logic     empty
);

   item_type             mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [Q_PTR_W:0]     count_ff, count_in;
   logic                 push, pop;

   assign full    = count_ff == (Q_PTR_W+1)'(Q_DEPTH);
   assign empty   = count_ff == '0;
   assign push    = wr_en && !full;
   assign pop     = rd_en && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

/* sv/rvg_back.sv */
// Back end: pipelined angle divider, 28-stage CORDIC, scale and offset.
// Depends on rvg_pkg and rvg_rsp_if.
module rvg_back import rvg_pkg::*; #(
   parameter int ANGLE_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  item_type                  item,
   input  logic                      item_valid,
   output logic                      item_pop,
   input  logic signed [COORD_W-1:0] center_x,
   input  logic signed [COORD_W-1:0] center_y,
   input  logic [RAD_W-1:0]          radius,
   rvg_rsp_if.source                 rsp
);

   localparam int NST   = ANGLE_BITS + CORDIC_STAGES + 4;
   localparam int ST_A  = ANGLE_BITS;
   localparam int ST_RS = ANGLE_BITS + CORDIC_STAGES + 1;
   localparam int ST_M  = ST_RS + 1;
   localparam int ST_O  = ST_M + 1;
   localparam int RW    = SIDES_W + 2;

   function automatic logic signed [COORD_W-1:0] sat32(input logic signed [63:0] v);
      logic signed [COORD_W-1:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

   logic [NST-1:0] vld_ff, rng_ff, lst_ff;
   logic           adv;

   assign adv      = !vld_ff[NST-1] || rsp.ready;
   assign item_pop = adv && item_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         rng_ff <= '0;
         lst_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NST-2:0], item_valid};
         rng_ff <= {rng_ff[NST-2:0], item.in_range};
         lst_ff <= {lst_ff[NST-2:0], item.last};
      end
   end

   logic [RW-1:0]         rem_ff [ANGLE_BITS];
   logic [SIDES_W:0]      den_ff [ANGLE_BITS];
   logic [ANGLE_BITS-1:0] q_ff   [ANGLE_BITS];

   for (genvar j = 0; j < ANGLE_BITS; j++) begin : g_div
      logic [RW-1:0]         rem_src, t, rem_in;
      logic [SIDES_W:0]      den_src;
      logic [ANGLE_BITS-1:0] q_src, q_in;
      logic                  ge;
      if (j == 0) begin : g_first
         assign rem_src = {1'b0, item.num};
         assign den_src = item.den;
         assign q_src   = '0;
      end else begin : g_next
         assign rem_src = rem_ff[j-1];
         assign den_src = den_ff[j-1];
         assign q_src   = q_ff[j-1];
      end
      assign t      = {rem_src[RW-2:0], 1'b0};
      assign ge     = t >= {1'b0, den_src};
      assign rem_in = ge ? t - {1'b0, den_src} : t;
      assign q_in   = {q_src[ANGLE_BITS-2:0], ge};
      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[j] <= rem_in;
            den_ff[j] <= den_src;
            q_ff[j]   <= q_in;
         end
      end
   end

   logic signed [CW-1:0] cx_ff [CORDIC_STAGES+1];
   logic signed [CW-1:0] cy_ff [CORDIC_STAGES+1];
   logic signed [CW-1:0] cz_ff [CORDIC_STAGES+1];
   logic [1:0]           quad_ff [CORDIC_STAGES+1];

   logic [ANGLE_BITS-1:0] ang;
   logic [31:0]           ang32, resid;
   logic [31:0]           rnd;

   always_comb begin
      ang   = q_ff[ANGLE_BITS-1] + ANGLE_BITS'(1 << (ANGLE_BITS-2));
      ang32 = {ang, {(32-ANGLE_BITS){1'b0}}};
      rnd   = ang32 + 32'h20000000;
      resid = ang32 - {rnd[31:30], 30'd0};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cx_ff[0]   <= $signed({2'b00, CORDIC_GAIN});
         cy_ff[0]   <= '0;
         cz_ff[0]   <= $signed({{2{resid[31]}}, resid});
         quad_ff[0] <= rnd[31:30];
      end
   end

   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
      logic signed [CW-1:0] dx, dy, at;
      assign dx = cy_ff[k] >>> k;
      assign dy = cx_ff[k] >>> k;
      assign at = $signed({2'b00, ATAN_TABLE[k]});
      always_ff @(posedge clock) begin
         if (adv) begin
            quad_ff[k+1] <= quad_ff[k];
            if (!cz_ff[k][CW-1]) begin
               cx_ff[k+1] <= cx_ff[k] - dx;
               cy_ff[k+1] <= cy_ff[k] + dy;
               cz_ff[k+1] <= cz_ff[k] - at;
            end else begin
               cx_ff[k+1] <= cx_ff[k] + dx;
               cy_ff[k+1] <= cy_ff[k] - dy;
               cz_ff[k+1] <= cz_ff[k] + at;
            end
         end
      end
   end

   logic signed [CW-1:0] cos_ff, sin_ff, cos_in, sin_in;
   logic signed [CW-1:0] fx, fy;

   assign fx = cx_ff[CORDIC_STAGES];
   assign fy = cy_ff[CORDIC_STAGES];

   always_comb begin
      unique case (quad_ff[CORDIC_STAGES])
         2'd0: begin
            cos_in = fx;
            sin_in = fy;
         end
         2'd1: begin
            cos_in = -fy;
            sin_in = fx;
         end
         2'd2: begin
            cos_in = -fx;
            sin_in = -fy;
         end
         default: begin
            cos_in = fy;
            sin_in = -fx;
         end
      endcase
   end

   logic signed [63:0] px_ff, py_ff;
   logic signed [COORD_W-1:0] rad_s;

   assign rad_s = $signed({1'b0, radius});

   always_ff @(posedge clock) begin
      if (adv) begin
         cos_ff <= cos_in;
         sin_ff <= sin_in;
         px_ff  <= rad_s * $signed(cos_ff[31:0]);
         py_ff  <= rad_s * $signed(sin_ff[31:0]);
      end
   end

   logic signed [63:0] sx, sy;
   logic signed [COORD_W-1:0] x_ff, y_ff;

   always_comb begin
      sx = 64'(center_x) + ((px_ff + 64'sd536870912) >>> 30);
      sy = 64'(center_y) + ((py_ff + 64'sd536870912) >>> 30);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff <= rng_ff[ST_M] ? sat32(sx) : '0;
         y_ff <= rng_ff[ST_M] ? sat32(sy) : '0;
      end
   end

   assign rsp.valid    = vld_ff[ST_O];
   assign rsp.x        = x_ff;
   assign rsp.y        = y_ff;
   assign rsp.in_range = rng_ff[ST_O];
   assign rsp.last     = lst_ff[ST_O];

   a_div_bits: assert property (@(posedge clock) disable iff (reset)
      vld_ff[0] && rng_ff[0] |-> rem_ff[0] < {1'b0, den_ff[0]})
      else $error("divider remainder not below divisor");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> $stable(x_ff) && $stable(y_ff))
      else $error("result changed while stalled");
   a_stage_a: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_A] |-> !(cz_ff[0] > $signed(CW'(32'sd536870912))))
      else $error("CORDIC residue out of octant");
   a_rs: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_RS] |-> (cos_ff <= $signed(CW'(34'sd1207959552))))
      else $error("cosine magnitude too large");

endmodule

/* sv/regular_polygon_vertex_generator_core.sv */
// Regular polygon vertex generator: for each request transfer carrying a vertex
// index, returns one response transfer with the vertex coordinates in Q16.16,
// saturated, plus in_range and last flags. One index is taken per clock unless
// the queue is full; the pipeline is made of the bit-per-stage angle divider
// (ANGLE_BITS stages), the 28-stage CORDIC and the multiply and offset stages.
// A four-entry queue separates the front end from the pipeline.
module regular_polygon_vertex_generator_core import rvg_pkg::*; #(
   parameter int MAX_SIDES  = 64,
   parameter int ANGLE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   rvg_req_if.sink               req_ch,
   rvg_rsp_if.source             rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic signed [COORD_W-1:0] center_x_ff, center_y_ff;
   logic [RAD_W-1:0]          radius_ff;
   logic [SIDES_W-1:0]        sides_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         radius_ff   <= RAD_W'(32768);
         sides_ff    <= SIDES_W'(4);
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_CENTER_X: center_x_ff <= csr_wdata;
            CSR_CENTER_Y: center_y_ff <= csr_wdata;
            CSR_RADIUS:   radius_ff   <= csr_wdata[RAD_W-1:0];
            CSR_SIDES:    sides_ff    <= csr_wdata[SIDES_W-1:0];
            default: ;
         endcase
      end
   end

   item_type fe_item, q_item;
   logic     fe_valid, q_full, q_empty, q_pop;

   rvg_front #(.MAX_SIDES(MAX_SIDES)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .sides      (sides_ff),
      .item       (fe_item),
      .item_valid (fe_valid),
      .item_ready (!q_full)
   );

   rvg_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (fe_valid),
      .wr_data (fe_item),
      .full    (q_full),
      .rd_en   (q_pop),
      .rd_data (q_item),
      .empty   (q_empty)
   );

   rvg_back #(.ANGLE_BITS(ANGLE_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .item       (q_item),
      .item_valid (!q_empty),
      .item_pop   (q_pop),
      .center_x   (center_x_ff),
      .center_y   (center_y_ff),
      .radius     (radius_ff),
      .rsp        (rsp_ch)
   );

   a_last_rng: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.last |-> rsp_ch.in_range)
      else $error("last set on out-of-range vertex");
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.in_range |-> rsp_ch.x == '0 && rsp_ch.y == '0)
      else $error("out-of-range vertex has nonzero coordinates");
   a_rdy: assert property (@(posedge clock) disable iff (reset)
      !q_full |-> req_ch.ready)
      else $error("front stalled with queue space free");

endmodule

/* bench/rvg_vertex_checker.sv */
// Checker for the regular polygon vertex generator: watches both channels,
// predicts each vertex from its own copy of the registers and compares.
// Depends on rvg_pkg and the rvg_req_if / rvg_rsp_if interfaces.
module rvg_vertex_checker import rvg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   rvg_req_if.monitor            req_mon,
   rvg_rsp_if.monitor            rsp_mon,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatch_count,
   output int                    pending_count
);

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic               in_range;
      logic               last;
   } vertex_type;

   localparam int MAX_SIDES  = 64;
   localparam int ANGLE_BITS = 16;

   logic signed [31:0] shadow_cx, shadow_cy;
   logic [30:0]        shadow_radius;
   logic [6:0]         shadow_sides;
   vertex_type         vertex_queue[$];

   function automatic longint floor_shr(longint v, int k);
      return v >>> k;
   endfunction

   function automatic logic signed [31:0] place_coord(logic signed [31:0] center,
                                                      longint trig);
      longint p, v;
      p = longint'({33'd0, shadow_radius}) * trig;
      v = longint'(center) + floor_shr(p + 64'sd536870912, 30);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
   endfunction

   function automatic vertex_type predict_vertex(logic [IDX_W-1:0] idx);
      vertex_type  v;
      int unsigned s, e, a;
      logic [31:0] ang, resid;
      logic [1:0]  quad;
      longint      cx, sy, z, dx, dy, cs, sn;
      v = '0;
      s = (shadow_sides > MAX_SIDES) ? MAX_SIDES : shadow_sides;
      if (s == 0 || idx >= s) return v;
      e = (s % 2 == 0) ? 1 : 0;
      a = (((2 * idx + e) << ANGLE_BITS) / (2 * s)) + (1 << (ANGLE_BITS - 2));
      a = a & ((1 << ANGLE_BITS) - 1);
      ang = a << (32 - ANGLE_BITS);
      quad = (ang + 32'h2000_0000) >> 30;
      resid = ang - ({30'd0, quad} << 30);
      z = longint'(signed'(resid));
      cx = CORDIC_GAIN;
      sy = 0;
      for (int k = 0; k < CORDIC_STAGES; k++) begin
         dx = floor_shr(sy, k);
         dy = floor_shr(cx, k);
         if (z >= 0) begin
            cx -= dx; sy += dy; z -= longint'(ATAN_TABLE[k]);
         end else begin
            cx += dx; sy -= dy; z += longint'(ATAN_TABLE[k]);
         end
      end
      case (quad)
         2'd0: begin cs = cx; sn = sy; end
         2'd1: begin cs = -sy; sn = cx; end
         2'd2: begin cs = -cx; sn = -sy; end
         default: begin cs = sy; sn = -cx; end
      endcase
      v.x = place_coord(shadow_cx, cs);
      v.y = place_coord(shadow_cy, sn);
      v.in_range = 1'b1;
      v.last = (idx == s - 1);
      return v;
   endfunction

   assign pending_count = vertex_queue.size();

   always @(posedge clock) begin
      vertex_type want, got;
      if (reset) begin
         shadow_cx <= 0;
         shadow_cy <= 0;
         shadow_radius <= 31'd32768;
         shadow_sides <= 7'd4;
         mismatch_count <= 0;
         vertex_queue.delete();
      end else begin
         if (csr_we) begin
            case (csr_idx_type'(csr_index))
               CSR_CENTER_X: shadow_cx <= csr_wdata;
               CSR_CENTER_Y: shadow_cy <= csr_wdata;
               CSR_RADIUS:   shadow_radius <= csr_wdata[30:0];
               CSR_SIDES:    shadow_sides <= csr_wdata[6:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            vertex_queue.insert(vertex_queue.size(),
                                predict_vertex(req_mon.vertex_index));
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.x, rsp_mon.y, rsp_mon.in_range, rsp_mon.last};
            if (vertex_queue.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected vertex transfer x=%0d y=%0d", got.x, got.y);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = vertex_queue.pop_front();
               if (got !== want) begin
                  if (mismatch_count < 10)
                     $display({"vertex mismatch: exp x=%0d y=%0d r=%b l=%b",
                               " got x=%0d y=%0d r=%b l=%b"},
                              want.x, want.y, want.in_range, want.last,
                              got.x, got.y, got.in_range, got.last);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
      end
   end

endmodule

/* bench/tb_regular_polygon_vertex_generator_core.sv */
// Testbench top for regular_polygon_vertex_generator_core: drives registers and
// vertex indices under varied idling and gives the verdict from the checker.
// Depends on rvg_pkg, the channel interfaces, the core and rvg_vertex_checker.
module tb_regular_polygon_vertex_generator_core import rvg_pkg::*; ();

   localparam int LATENCY     = 60;
   localparam int CYCLE_LIMIT = 400000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   int                    mismatch_count, pending_count;
   int                    cycle_count = 0;
   int                    send_idle_pct = 0, stall_pct = 0;
   int                    hold_off = 0;

   rvg_req_if req_ch();
   rvg_rsp_if rsp_ch();

   regular_polygon_vertex_generator_core dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   rvg_vertex_checker checker_i (
      .clock(clock), .reset(reset), .req_mon(req_ch.monitor), .rsp_mon(rsp_ch.monitor),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .mismatch_count(mismatch_count), .pending_count(pending_count)
   );

   initial begin
      req_ch.valid = 1'b0;
      req_ch.vertex_index = '0;
      rsp_ch.ready = 1'b0;
   end

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ch.ready <= 1'b0;
      end else
         rsp_ch.ready <= reset ? 1'b0 : ($urandom_range(99) >= stall_pct);
   end

   task automatic write_reg(csr_idx_type idx, logic [31:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain_block();
      req_ch.valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic send_index(logic [IDX_W-1:0] idx);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.vertex_index <= idx;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic set_polygon(logic [31:0] cx, logic [31:0] cy, logic [31:0] r,
                              logic [31:0] s);
      drain_block();
      write_reg(CSR_CENTER_X, cx);
      write_reg(CSR_CENTER_Y, cy);
      write_reg(CSR_RADIUS, r);
      write_reg(CSR_SIDES, s);
   endtask

   task automatic random_phase(int count);
      for (int n = 0; n < count; n++)
         send_index(IDX_W'(($urandom_range(9) == 0) ? $urandom_range(63)
                    : $urandom_range((checker_i.shadow_sides == 0) ? 63
                                     : checker_i.shadow_sides - 1)));
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < 6; i++) send_index(i);
      set_polygon(32'sh7fff_ffff, 32'sh8000_0000, 32'h7fff_ffff, 3);
      for (int i = 0; i < 4; i++) send_index(i);
      set_polygon(32'h0001_0000, 32'hffff_0000, 0, 64);
      send_index(0); send_index(63);
      set_polygon(0, 0, 32'h0010_0000, 0);
      send_index(0); send_index(63);
      set_polygon(32'h1234_5678, 32'h8765_4321, 32'hffff_ffff, 127);
      send_index(63); send_index(31); send_index(0);
      set_polygon(0, 0, 32'h0001_0000, 1);
      send_index(0); send_index(1);
      hold_off <= 300;
      random_phase(80);
      for (int ph = 0; ph < 8; ph++) begin
         set_polygon($urandom, $urandom, (ph % 3 == 0) ? $urandom : $urandom_range(1 << 22),
                     (ph == 7) ? 64 : $urandom_range(1, 70));
         send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? 66 : 0;
         stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? 66 : 0;
         if (ph % 4 == 3) begin
            send_idle_pct = 11;
            stall_pct = 11;
         end
         random_phase(145);
      end
      drain_block();
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

/* filelist.f */
sv/rvg_pkg.sv
sv/rvg_req_if.sv
sv/rvg_rsp_if.sv
sv/rvg_front.sv
sv/rvg_fifo.sv
sv/rvg_back.sv
sv/regular_polygon_vertex_generator_core.sv
bench/rvg_vertex_checker.sv
bench/tb_regular_polygon_vertex_generator_core.sv
